// File: design/ssnf_pkg.sv
// ----------------------------------------------------------------------------
// ssnf_pkg
// Types, codes and segment table shared by the number formatter modules.
// ----------------------------------------------------------------------------
package ssnf_pkg;

    // display mode codes
    localparam logic [1:0] MODE_DEC      = 2'd0;
    localparam logic [1:0] MODE_DEC_CODE = 2'd1;
    localparam logic [1:0] MODE_HEX      = 2'd2;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // digit count codes
    localparam logic [2:0] DMODE_KEEP_MAX = 3'd3;
    localparam logic [2:0] DMODE_AUTO     = 3'd5;

    // decimal range limits
    localparam logic [15:0] DEC_MAX      = 16'd9999;
    localparam logic [15:0] DEC_CODE_MAX = 16'd999;

    // decimal weights
    localparam logic [15:0] W_THOUSANDS = 16'd1000;
    localparam logic [15:0] W_HUNDREDS  = 16'd100;
    localparam logic [15:0] W_TENS      = 16'd10;

    // leading zero masks for hexadecimal
    localparam logic [15:0] HEX_MASK_1 = 16'hFFF0;
    localparam logic [15:0] HEX_MASK_2 = 16'hFF00;
    localparam logic [15:0] HEX_MASK_3 = 16'hF000;

    localparam logic [7:0] DOT_BIT = 8'h80;

    localparam int NUM_DIGITS = 4;

    typedef logic [3:0] digit_t;

    // word moving through the decimal split stages
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
        logic [7:0]  code;
        logic [2:0]  digit_mode;
        logic [3:0]  dots;
        logic        reject;
        logic [9:0]  rem;
        digit_t      thousands;
        digit_t      hundreds;
    } work_t;

    // word handed from the split stages to the encoder
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] value;
        logic [7:0]  code;
        logic [2:0]  digit_mode;
        logic [3:0]  dots;
        logic        reject;
        digit_t      thousands;
        digit_t      hundreds;
        digit_t      tens;
        digit_t      units;
    } split_word_t;

    // one decimal digit of v at the given weight, capped at nine
    function automatic digit_t dec_digit(input logic [15:0] v, input logic [15:0] weight);
        digit_t      d;
        logic [15:0] thr;
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            thr = 16'(k) * weight;
            if (v >= thr) begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

    // seven-segment pattern, bit 0 segment a to bit 6 segment g
    function automatic logic [7:0] seg_glyph(input digit_t d);
        logic [7:0] s;
        case (d)
            4'h0: s = 8'h3F;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5B;
            4'h3: s = 8'h4F;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6D;
            4'h6: s = 8'h7D;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7F;
            4'h9: s = 8'h6F;
            4'hA: s = 8'h77;
            4'hB: s = 8'h7C;
            4'hC: s = 8'h39;
            4'hD: s = 8'h5E;
            4'hE: s = 8'h79;
            4'hF: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: design/ssnf_channels.sv
// ----------------------------------------------------------------------------
// ssnf channels
// Valid/ready channel interfaces for the input word and the result word.
// ----------------------------------------------------------------------------
interface ssnf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] value;
    logic [7:0]  code;
    logic [2:0]  digit_mode;
    logic [3:0]  dots;

    modport source (output valid, output mode, output value, output code,
                    output digit_mode, output dots, input ready);
    modport sink   (input valid, input mode, input value, input code,
                    input digit_mode, input dots, output ready);
endinterface

interface ssnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit0_segments;
    logic [7:0] digit1_segments;
    logic [7:0] digit2_segments;
    logic [7:0] digit3_segments;
    logic       rejected;

    modport source (output valid, output digit0_segments, output digit1_segments,
                    output digit2_segments, output digit3_segments,
                    output rejected, input ready);
    modport sink   (input valid, input digit0_segments, input digit1_segments,
                    input digit2_segments, input digit3_segments,
                    input rejected, output ready);
endinterface

// File: design/seven_segment_number_formatter.sv
// ----------------------------------------------------------------------------
// seven_segment_number_formatter
// Four-digit seven-segment formatter, decimal, decimal with code digit or hex.
// ----------------------------------------------------------------------------
// in_ch carries one word per value: mode, value, code, digit_mode and dots.
// out_ch returns one word per input word: four segment bytes, units first,
// and a reject flag that comes with all segment bytes at zero.
// Both channels move a word on a rising edge with valid and ready high.
// The path is four register stages: range check and thousands digit,
// hundreds digit, tens and units digits, then segment lookup and blanking
// into the output register, which a word passes through in that order. One
// word can be accepted every cycle while the receiver keeps ready high;
// the stage stall chain lets each stage hold one word.
// While the receiver holds ready low the output word stays put and the
// stages behind it keep filling; in_ch ready drops once all four hold a
// word. Reset empties every stage; no word is lost or repeated on a stall.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ssnf_in_if.sink    in_ch,
    ssnf_out_if.source out_ch
);

    logic        split_valid;
    logic        split_ready;
    split_word_t split_word;

    ssnf_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_word  (split_word)
    );

    ssnf_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (split_valid),
        .in_ready (split_ready),
        .in_word  (split_word),
        .out_ch   (out_ch)
    );

    // a rejected word never lights a segment
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.rejected) |->
        ((out_ch.digit0_segments == 8'h00) && (out_ch.digit1_segments == 8'h00) &&
         (out_ch.digit2_segments == 8'h00) && (out_ch.digit3_segments == 8'h00)))
        else $error("rejected word with lit segments");

    // an empty or draining output stage means the whole path can take a word
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
        else $error("input stalled with free output stage");

    // a reserved mode word comes out rejected while the output keeps ready high
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.mode == MODE_RESERVED))
        ##1 out_ch.ready ##1 out_ch.ready ##1 out_ch.ready
        |=> (out_ch.valid && out_ch.rejected))
        else $error("reserved mode word not rejected on time");

endmodule

// File: design/ssnf_split.sv
// ----------------------------------------------------------------------------
// ssnf_split
// Three register stages that range-check the value and peel off the
// decimal digits: thousands, hundreds, then tens and units.
// ----------------------------------------------------------------------------
module ssnf_split
    import ssnf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ssnf_in_if.sink       in_ch,
    output logic          out_valid,
    input  logic          out_ready,
    output split_word_t   out_word
);

    logic        s1_valid_reg;
    work_t       s1_reg;
    work_t       s1_next;
    logic        s1_ready;

    logic        s2_valid_reg;
    work_t       s2_reg;
    work_t       s2_next;
    logic        s2_ready;

    logic        s3_valid_reg;
    split_word_t s3_reg;
    split_word_t s3_next;
    logic        s3_ready;

    digit_t      tens_digit;

    // stall chain: a stage takes a word when empty or when it drains
    assign s3_ready    = !s3_valid_reg || out_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_ch.ready = s1_ready;

    // stage 1: range check and thousands digit
    always_comb
    begin
        s1_next.mode       = in_ch.mode;
        s1_next.value      = in_ch.value;
        s1_next.code       = in_ch.code;
        s1_next.digit_mode = in_ch.digit_mode;
        s1_next.dots       = in_ch.dots;
        s1_next.reject     = (in_ch.mode == MODE_RESERVED) ||
                             ((in_ch.mode == MODE_DEC) && (in_ch.value > DEC_MAX)) ||
                             ((in_ch.mode == MODE_DEC_CODE) && (in_ch.value > DEC_CODE_MAX));
        s1_next.thousands  = dec_digit(in_ch.value, W_THOUSANDS);
        s1_next.rem        = 10'(in_ch.value - 16'(s1_next.thousands) * W_THOUSANDS);
        s1_next.hundreds   = 4'd0;
    end

    // stage 2: hundreds digit
    always_comb
    begin
        s2_next          = s1_reg;
        s2_next.hundreds = dec_digit(16'(s1_reg.rem), W_HUNDREDS);
        s2_next.rem      = 10'(16'(s1_reg.rem) - 16'(s2_next.hundreds) * W_HUNDREDS);
    end

    // stage 3: tens and units digits
    always_comb
    begin
        tens_digit           = dec_digit(16'(s2_reg.rem), W_TENS);
        s3_next.mode         = s2_reg.mode;
        s3_next.value        = s2_reg.value;
        s3_next.code         = s2_reg.code;
        s3_next.digit_mode   = s2_reg.digit_mode;
        s3_next.dots         = s2_reg.dots;
        s3_next.reject       = s2_reg.reject;
        s3_next.thousands    = s2_reg.thousands;
        s3_next.hundreds     = s2_reg.hundreds;
        s3_next.tens         = tens_digit;
        s3_next.units        = 4'(16'(s2_reg.rem) - 16'(tens_digit) * W_TENS);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_ch.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_word  = s3_reg;

endmodule

// File: design/ssnf_encode.sv
// ----------------------------------------------------------------------------
// ssnf_encode
// Segment lookup, dots, digit blanking and the output register.
// ----------------------------------------------------------------------------
module ssnf_encode
    import ssnf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  split_word_t   in_word,
    ssnf_out_if.source    out_ch
);

    logic       out_valid_reg;
    logic [7:0] seg_reg  [NUM_DIGITS];
    logic [7:0] seg_next [NUM_DIGITS];
    logic       rejected_reg;
    digit_t     nib [NUM_DIGITS];
    logic [2:0] keep;
    logic       hex_mode;

    assign in_ready = !out_valid_reg || out_ch.ready;
    assign hex_mode = (in_word.mode == MODE_HEX);

    // digit values for the selected radix
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            nib[k] = in_word.value[4*k +: 4];
        end
        if (!hex_mode)
        begin
            nib[0] = in_word.units;
            nib[1] = in_word.tens;
            nib[2] = in_word.hundreds;
            nib[3] = in_word.thousands;
        end
    end

    // number of low digits that stay lit
    always_comb
    begin
        keep = 3'd4;
        if (in_word.digit_mode == DMODE_AUTO)
        begin
            if (hex_mode)
            begin
                if ((in_word.value & HEX_MASK_1) == 16'd0)
                    keep = 3'd1;
                else if ((in_word.value & HEX_MASK_2) == 16'd0)
                    keep = 3'd2;
                else if ((in_word.value & HEX_MASK_3) == 16'd0)
                    keep = 3'd3;
            end
            else
            begin
                if (in_word.value < W_TENS)
                    keep = 3'd1;
                else if (in_word.value < W_HUNDREDS)
                    keep = 3'd2;
                else if (in_word.value < W_THOUSANDS)
                    keep = 3'd3;
            end
        end
        if (in_word.digit_mode inside {[3'd0:DMODE_KEEP_MAX]})
        begin
            keep = in_word.digit_mode;
        end
    end

    // glyphs with dots, code digit and blanking
    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            seg_next[k] = seg_glyph(nib[k]) | (in_word.dots[k] ? DOT_BIT : 8'h00);
        end
        if (in_word.mode == MODE_DEC_CODE)
        begin
            seg_next[NUM_DIGITS-1] = in_word.code;
        end
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            // the code digit survives leading zero blanking
            if ((3'(k) >= keep) &&
                !((in_word.mode == MODE_DEC_CODE) && (k == NUM_DIGITS-1) &&
                  (in_word.digit_mode == DMODE_AUTO)))
            begin
                seg_next[k] = 8'h00;
            end
            if (in_word.reject)
            begin
                seg_next[k] = 8'h00;
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            seg_reg      <= seg_next;
            rejected_reg <= in_word.reject;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.digit0_segments = seg_reg[0];
    assign out_ch.digit1_segments = seg_reg[1];
    assign out_ch.digit2_segments = seg_reg[2];
    assign out_ch.digit3_segments = seg_reg[3];
    assign out_ch.rejected        = rejected_reg;

endmodule
